>>> rtl/osc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc_pkg
// shared types, codes and defaults of the operand stack engine
// ----------------------------------------------------------------------------
package osc_pkg;

  localparam int unsigned STACK_DEPTH_DEF  = 512;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  // fixed field widths of the channels
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned ARG_W   = 32;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CNT_W   = 10;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_EXCH  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DUP   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_COPY  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_INDEX = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ROLL  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 4'd7;
  localparam logic [CMD_W-1:0] CMD_COUNT = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CLTM  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_CNTM  = 4'd10;

  typedef enum logic [3:0] {
    OP_PUSH, OP_POP, OP_EXCH, OP_DUP, OP_COPY, OP_INDEX, OP_ROLL,
    OP_CLEAR, OP_COUNT, OP_CLTM, OP_CNTM, OP_BAD
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_UNDER  = 3'd2,
    ST_OVER   = 3'd3,
    ST_NOMARK = 3'd4
  } status_e;

  // classified command as queued between front and back
  typedef struct packed {
    op_e                op;
    logic [VALUE_W-1:0] value;
    logic               mark;
    logic               n_neg;
    logic [ARG_W-2:0]   n_mag;
    logic               j_neg;
    logic [ARG_W-1:0]   j_mag;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/osc_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc channel interfaces
// valid/ready channels for commands in and results out
// ----------------------------------------------------------------------------
interface osc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [63:0] push_value;
  logic        push_is_mark;
  logic signed [31:0] count_arg;
  logic signed [31:0] roll_shift;

  modport source (output valid, cmd, push_value, push_is_mark, count_arg, roll_shift,
                  input ready);
  modport sink (input valid, cmd, push_value, push_is_mark, count_arg, roll_shift,
                output ready);
endinterface

interface osc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] top_value;
  logic        top_is_mark;
  logic [9:0]  stack_depth;
  logic [9:0]  count_result;

  modport source (output valid, status, top_value, top_is_mark, stack_depth, count_result,
                  input ready);
  modport sink (input valid, status, top_value, top_is_mark, stack_depth, count_result,
                output ready);
endinterface
`default_nettype wire

>>> rtl/osc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc_front
// accepts commands, decodes them and queues them for the back end
// ----------------------------------------------------------------------------
module osc_front (
  input  wire         clk_i,
  input  wire         rst_ni,
  osc_in_if.sink      in_i,
  output logic        q_valid_o,
  output osc_pkg::cmd_t q_cmd_o,
  input  wire         q_pop_i
);
  import osc_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // decode the transaction
  always_comb begin
    unique case (in_i.cmd)
      CMD_PUSH:  dec.op = OP_PUSH;
      CMD_POP:   dec.op = OP_POP;
      CMD_EXCH:  dec.op = OP_EXCH;
      CMD_DUP:   dec.op = OP_DUP;
      CMD_COPY:  dec.op = OP_COPY;
      CMD_INDEX: dec.op = OP_INDEX;
      CMD_ROLL:  dec.op = OP_ROLL;
      CMD_CLEAR: dec.op = OP_CLEAR;
      CMD_COUNT: dec.op = OP_COUNT;
      CMD_CLTM:  dec.op = OP_CLTM;
      CMD_CNTM:  dec.op = OP_CNTM;
      default:   dec.op = OP_BAD;
    endcase
    dec.value = in_i.push_value;
    dec.mark  = in_i.push_is_mark;
    dec.n_neg = in_i.count_arg[ARG_W-1];
    dec.n_mag = in_i.count_arg[ARG_W-2:0];
    dec.j_neg = in_i.roll_shift[ARG_W-1];
    dec.j_mag = dec.j_neg ? (~in_i.roll_shift + 32'd1) : in_i.roll_shift;
  end

  assign in_i.ready = (fill_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (fill_q != 2'd0);
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_cmd_o    = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/osc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc_back
// executes queued commands on the stack memory and registers the result
// ----------------------------------------------------------------------------
module osc_back #(
  parameter int unsigned STACK_DEPTH  = osc_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = osc_pkg::PAYLOAD_BITS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           q_valid_i,
  input  osc_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  osc_out_if.source     out_o
);
  import osc_pkg::*;

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned ELW = PAYLOAD_BITS + 1;
  localparam logic [SPW-1:0] FULL = SPW'(STACK_DEPTH);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EXEC  = 5'd1;
  localparam logic [4:0] S_DUPW  = 5'd2;
  localparam logic [4:0] S_CPRD  = 5'd3;
  localparam logic [4:0] S_CPWR  = 5'd4;
  localparam logic [4:0] S_DIV   = 5'd5;
  localparam logic [4:0] S_ROTS  = 5'd6;
  localparam logic [4:0] S_REV   = 5'd7;
  localparam logic [4:0] S_SWRA  = 5'd8;
  localparam logic [4:0] S_SWRB  = 5'd9;
  localparam logic [4:0] S_SWWA  = 5'd10;
  localparam logic [4:0] S_SWWB  = 5'd11;
  localparam logic [4:0] S_MKRD  = 5'd12;
  localparam logic [4:0] S_MKCHK = 5'd13;
  localparam logic [4:0] S_REP   = 5'd14;
  localparam logic [4:0] S_OUT   = 5'd15;

  logic [ELW-1:0] mem [STACK_DEPTH];
  logic [ELW-1:0] rdata_q;

  logic [4:0]     state_q, state_d;
  cmd_t           cur_q, cur_d;
  logic [SPW-1:0] sp_q, sp_d;
  status_e        status_q, status_d;
  logic [SPW-1:0] cnt_q, cnt_d;
  logic           popped_q, popped_d;
  logic [SPW-1:0] k_q, k_d;
  logic [AW-1:0]  base_q, base_d;
  logic [SPW-1:0] idx_q, idx_d;
  logic [SPW-1:0] rem_q, rem_d;
  logic [ARG_W-1:0] jm_q, jm_d;
  logic [4:0]     dc_q, dc_d;
  logic [SPW-1:0] s_q, s_d;
  logic [AW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [1:0]     ph_q, ph_d;
  logic [AW-1:0]  sa_q, sa_d, sb_q, sb_d;
  logic [ELW-1:0] tmp_q, tmp_d;

  logic           ov_q, ov_d;
  logic [ST_W-1:0] o_status_q, o_status_d;
  logic [VALUE_W-1:0] o_top_q, o_top_d;
  logic           o_mark_q, o_mark_d;
  logic [CNT_W-1:0] o_depth_q, o_depth_d, o_cnt_q, o_cnt_d;

  logic           we;
  logic [AW-1:0]  wa, ra;
  logic [ELW-1:0] wd;

  logic [ARG_W-1:0] sp32, n32;
  logic [SPW-1:0] nk;
  logic [SPW:0]   csum, rem_sh;
  logic [SPW-1:0] s_calc;
  logic [ARG_W-1:0] w_sp, w_cnt, w_dep;
  logic [VALUE_W-1:0] v_sp, v_idx;
  logic [AW-1:0]  sp_a;
  logic           full;

  always_comb begin
    sp32   = ARG_W'(sp_q);
    n32    = {1'b0, cur_q.n_mag};
    nk     = cur_q.n_mag[SPW-1:0];
    csum   = {1'b0, sp_q} + {1'b0, nk};
    rem_sh = {rem_q, jm_q[ARG_W-1]};
    s_calc = (cur_q.j_neg && (rem_q != '0)) ? (k_q - rem_q) : rem_q;
    w_sp   = ARG_W'(sp_q);
    w_cnt  = ARG_W'(cnt_q);
    v_sp   = VALUE_W'(sp_q);
    v_idx  = VALUE_W'(idx_q);
    sp_a   = sp_q[AW-1:0];
    full   = (sp_q >= FULL);
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    sp_d     = sp_q;
    status_d = status_q;
    cnt_d    = cnt_q;
    popped_d = popped_q;
    k_d      = k_q;
    base_d   = base_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    jm_d     = jm_q;
    dc_d     = dc_q;
    s_d      = s_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ph_d     = ph_q;
    sa_d     = sa_q;
    sb_d     = sb_q;
    tmp_d    = tmp_q;
    ov_d     = ov_q;
    o_status_d = o_status_q;
    o_top_d  = o_top_q;
    o_mark_d = o_mark_q;
    o_depth_d = o_depth_q;
    o_cnt_d  = o_cnt_q;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    wa       = sp_a;
    wd       = rdata_q;
    // default read keeps the element reported by this command
    ra       = popped_q ? sp_a : (sp_a - AW'(1));
    w_dep    = '0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        status_d = ST_OK;
        cnt_d    = '0;
        popped_d = 1'b0;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_REP;
        unique case (cur_q.op)
          OP_PUSH: begin
            if (full) begin
              status_d = ST_OVER;
            end else begin
              we   = 1'b1;
              wd   = {cur_q.mark, cur_q.value[PAYLOAD_BITS-1:0]};
              sp_d = sp_q + SPW'(1);
            end
          end
          OP_POP: begin
            if (sp_q == '0) begin
              status_d = ST_UNDER;
            end else begin
              sp_d     = sp_q - SPW'(1);
              popped_d = 1'b1;
            end
          end
          OP_EXCH: begin
            if (sp_q < SPW'(2)) begin
              status_d = ST_UNDER;
            end else begin
              sa_d    = sp_a - AW'(1);
              sb_d    = sp_a - AW'(2);
              state_d = S_SWRA;
            end
          end
          OP_DUP: begin
            if (sp_q == '0) begin
              status_d = ST_UNDER;
            end else if (full) begin
              status_d = ST_OVER;
            end else begin
              ra      = sp_a - AW'(1);
              state_d = S_DUPW;
            end
          end
          OP_INDEX: begin
            if (cur_q.n_neg) begin
              status_d = ST_RANGE;
            end else if (n32 >= sp32) begin
              status_d = ST_UNDER;
            end else if (full) begin
              status_d = ST_OVER;
            end else begin
              ra      = sp_a - AW'(1) - cur_q.n_mag[AW-1:0];
              state_d = S_DUPW;
            end
          end
          OP_COPY: begin
            if (cur_q.n_neg) begin
              status_d = ST_RANGE;
            end else if (n32 > sp32) begin
              status_d = ST_UNDER;
            end else if (csum > (SPW+1)'(STACK_DEPTH)) begin
              status_d = ST_OVER;
            end else if (nk != '0) begin
              k_d     = nk;
              base_d  = sp_a - nk[AW-1:0];
              idx_d   = '0;
              state_d = S_CPRD;
            end
          end
          OP_ROLL: begin
            if (cur_q.n_neg) begin
              status_d = ST_RANGE;
            end else if (n32 > sp32) begin
              status_d = ST_UNDER;
            end else if (nk != '0) begin
              k_d     = nk;
              base_d  = sp_a - nk[AW-1:0];
              rem_d   = '0;
              jm_d    = cur_q.j_mag;
              dc_d    = '0;
              state_d = S_DIV;
            end
          end
          OP_CLEAR: begin
            sp_d = '0;
          end
          OP_COUNT: begin
            if (full) begin
              status_d = ST_OVER;
            end else begin
              we    = 1'b1;
              wd    = {1'b0, v_sp[PAYLOAD_BITS-1:0]};
              cnt_d = sp_q;
              sp_d  = sp_q + SPW'(1);
            end
          end
          OP_CLTM, OP_CNTM: begin
            if (sp_q == '0) begin
              status_d = ST_NOMARK;
            end else begin
              idx_d   = '0;
              state_d = S_MKRD;
            end
          end
          default: begin
            status_d = ST_RANGE;
          end
        endcase
      end

      // second half of dup and index: write the fetched element on top
      S_DUPW: begin
        we      = 1'b1;
        wd      = rdata_q;
        sp_d    = sp_q + SPW'(1);
        state_d = S_REP;
      end

      S_CPRD: begin
        ra      = base_q + idx_q[AW-1:0];
        state_d = S_CPWR;
      end

      S_CPWR: begin
        we    = 1'b1;
        wa    = sp_a + idx_q[AW-1:0];
        wd    = rdata_q;
        idx_d = idx_q + SPW'(1);
        if (idx_d == k_q) begin
          sp_d    = sp_q + k_q;
          state_d = S_REP;
        end else begin
          state_d = S_CPRD;
        end
      end

      // restoring remainder of |j| by n, one bit a cycle
      S_DIV: begin
        if (rem_sh >= {1'b0, k_q}) begin
          rem_d = SPW'(rem_sh - {1'b0, k_q});
        end else begin
          rem_d = rem_sh[SPW-1:0];
        end
        jm_d = jm_q << 1;
        dc_d = dc_q + 5'd1;
        if (dc_q == 5'd31) begin
          state_d = S_ROTS;
        end
      end

      S_ROTS: begin
        if (s_calc == '0) begin
          state_d = S_REP;
        end else begin
          s_d     = s_calc;
          lo_d    = base_q;
          hi_d    = base_q + k_q[AW-1:0] - AW'(1);
          ph_d    = 2'd0;
          state_d = S_REV;
        end
      end

      // rotation by three reversals: whole window, lower s, upper k-s
      S_REV: begin
        if (lo_q < hi_q) begin
          sa_d    = lo_q;
          sb_d    = hi_q;
          state_d = S_SWRA;
        end else begin
          unique case (ph_q)
            2'd0: begin
              lo_d = base_q;
              hi_d = base_q + s_q[AW-1:0] - AW'(1);
              ph_d = 2'd1;
            end
            2'd1: begin
              lo_d = base_q + s_q[AW-1:0];
              hi_d = base_q + k_q[AW-1:0] - AW'(1);
              ph_d = 2'd2;
            end
            default: begin
              state_d = S_REP;
            end
          endcase
        end
      end

      S_SWRA: begin
        ra      = sa_q;
        state_d = S_SWRB;
      end

      S_SWRB: begin
        ra      = sb_q;
        tmp_d   = rdata_q;
        state_d = S_SWWA;
      end

      S_SWWA: begin
        we      = 1'b1;
        wa      = sa_q;
        wd      = rdata_q;
        state_d = S_SWWB;
      end

      S_SWWB: begin
        we = 1'b1;
        wa = sb_q;
        wd = tmp_q;
        if (cur_q.op == OP_ROLL) begin
          lo_d    = lo_q + AW'(1);
          hi_d    = hi_q - AW'(1);
          state_d = S_REV;
        end else begin
          state_d = S_REP;
        end
      end

      // walk down from the top looking for a mark
      S_MKRD: begin
        ra      = sp_a - AW'(1) - idx_q[AW-1:0];
        state_d = S_MKCHK;
      end

      S_MKCHK: begin
        if (rdata_q[ELW-1]) begin
          state_d = S_REP;
          if (cur_q.op == OP_CLTM) begin
            sp_d = sp_q - SPW'(1) - idx_q;
          end else if (full) begin
            status_d = ST_OVER;
          end else begin
            we    = 1'b1;
            wd    = {1'b0, v_idx[PAYLOAD_BITS-1:0]};
            cnt_d = idx_q;
            sp_d  = sp_q + SPW'(1);
          end
        end else if ((idx_q + SPW'(1)) == sp_q) begin
          status_d = ST_NOMARK;
          state_d  = S_REP;
        end else begin
          idx_d   = idx_q + SPW'(1);
          state_d = S_MKRD;
        end
      end

      S_REP: begin
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          w_dep      = w_sp;
          ov_d       = 1'b1;
          o_status_d = status_q;
          if (popped_q || (sp_q != '0)) begin
            o_top_d  = VALUE_W'(rdata_q[PAYLOAD_BITS-1:0]);
            o_mark_d = rdata_q[ELW-1];
          end else begin
            o_top_d  = '0;
            o_mark_d = 1'b0;
          end
          o_depth_d = w_dep[CNT_W-1:0];
          o_cnt_d   = w_cnt[CNT_W-1:0];
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      sp_q       <= '0;
      ov_q       <= 1'b0;
      status_q   <= ST_OK;
      cnt_q      <= '0;
      popped_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      sp_q       <= sp_d;
      ov_q       <= ov_d;
      status_q   <= status_d;
      cnt_q      <= cnt_d;
      popped_q   <= popped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    k_q        <= k_d;
    base_q     <= base_d;
    idx_q      <= idx_d;
    rem_q      <= rem_d;
    jm_q       <= jm_d;
    dc_q       <= dc_d;
    s_q        <= s_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    ph_q       <= ph_d;
    sa_q       <= sa_d;
    sb_q       <= sb_d;
    tmp_q      <= tmp_d;
    o_status_q <= o_status_d;
    o_top_q    <= o_top_d;
    o_mark_q   <= o_mark_d;
    o_depth_q  <= o_depth_d;
    o_cnt_q    <= o_cnt_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.status       = o_status_q;
  assign out_o.top_value    = o_top_q;
  assign out_o.top_is_mark  = o_mark_q;
  assign out_o.stack_depth  = o_depth_q;
  assign out_o.count_result = o_cnt_q;

endmodule
`default_nettype wire

>>> rtl/operand_stack_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// operand_stack_engine_core
// operand stack with mark objects: push, pop, exch, dup, copy, index, roll,
// clear, count, cleartomark and counttomark, one result per command
// ----------------------------------------------------------------------------
// steps: push, pop, clear, count and rejected commands go through execute,
//   report and output; dup and index add a write of the fetched element;
//   exch adds reads and writes of both elements; copy n adds a read and a
//   write per element; a mark search adds a read and a check per element
//   walked; roll with n > 0 finds j mod n bit by bit, then swaps for the
//   three reversals; the back end sequencer runs one command at a time over
//   a memory with one read and one write port; a 2-entry queue decouples intake
// reset: stack empties at once; memory contents are not cleared
// ----------------------------------------------------------------------------
module operand_stack_engine_core #(
  parameter int unsigned STACK_DEPTH  = osc_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = osc_pkg::PAYLOAD_BITS_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  osc_in_if.sink    in_i,
  osc_out_if.source out_o
);
  import osc_pkg::*;

  // queue between decode and execution
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // front end: takes transactions, decodes the command, sign splits n and j
  osc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  // back end: stack memory, pointer and the command sequencer, result register
  osc_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire
